[hdl/psg_pkg.sv]
// Shared types and constants for the three-tone, one-noise sound generator.
// No dependencies; every other file in hdl/ but psg_checker.sv imports this package.
package psg_pkg;

    localparam int NumTones    = 3;
    localparam int ToneWidth   = 10;
    localparam int NoiseCntW   = 7;
    localparam int ShiftWidth  = 16;
    localparam int LenWidth    = 5;
    localparam int ReadyWidth  = 6;
    localparam int AttenWidth  = 4;
    localparam int PreWidth    = 16;

    localparam int CmdLatchBit = 7;

    localparam logic [ReadyWidth-1:0] ReadyLoad     = 6'd32;
    localparam logic [PreWidth-1:0]   TickDivReset  = 16'd16;
    localparam logic [ShiftWidth-1:0] TapsReset     = 16'd9;
    localparam logic [LenWidth-1:0]   LenReset      = 5'd16;
    localparam logic [ShiftWidth-1:0] SeedReset     = 16'd32768;
    localparam logic [1:0]            NoiseVoice    = 2'd3;

    typedef enum logic {
        OpWrite = 1'b0,
        OpTick  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        CfgTickDivider = 2'd0,
        CfgNoiseTaps   = 2'd1,
        CfgShiftLength = 2'd2,
        CfgShiftSeed   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic step;
        logic wr_lo;
        logic wr_hi;
    } t_tone_ctl;

    typedef struct packed {
        logic step;
        logic mode_wr;
    } t_noise_ctl;

    // Noise rate select: 16, 32 or 64 steps, or clocked from tone 2.
    function automatic logic [NoiseCntW-1:0] noise_rate(input logic [1:0] sel);
        logic [NoiseCntW-1:0] rate;
        unique case (sel)
            2'd0:    rate = 7'h10;
            2'd1:    rate = 7'h20;
            2'd2:    rate = 7'h40;
            default: rate = 7'h00;
        endcase
        return rate;
    endfunction

endpackage

[hdl/psg_tone.sv]
// One square-wave tone voice: period register, down counter and output bit.
// Depends on psg_pkg.
module psg_tone (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  psg_pkg::t_tone_ctl  i_ctl,
    input  logic [7:0]          i_data,
    output logic                o_next_bit
);
    import psg_pkg::*;

    logic [ToneWidth-1:0] r_period, n_period;
    logic [ToneWidth-1:0] r_count,  n_count;
    logic                 r_out,    n_out;
    logic [ToneWidth-1:0] count_dec;

    always_comb begin
        n_period  = r_period;
        n_count   = r_count;
        n_out     = r_out;
        count_dec = r_count - 1'b1;
        if (i_ctl.wr_lo) begin
            n_period = {r_period[ToneWidth-1:4], i_data[3:0]};
        end else if (i_ctl.wr_hi) begin
            n_period = {i_data[5:0], r_period[3:0]};
        end else if (i_ctl.step) begin
            // A period of 0 or 1 parks the output high without counting.
            if (r_period <= ToneWidth'(1)) begin
                n_out = 1'b1;
            end else if (count_dec == '0) begin
                n_count = r_period;
                n_out   = ~r_out;
            end else begin
                n_count = count_dec;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= '0;
            r_count  <= '0;
            r_out    <= 1'b0;
        end else begin
            r_period <= n_period;
            r_count  <= n_count;
            r_out    <= n_out;
        end
    end

    assign o_next_bit = n_out;

endmodule

[hdl/psg_noise.sv]
// Noise voice: rate counter, edge detect on tone 2 and configurable shift register.
// Depends on psg_pkg.
module psg_noise (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  psg_pkg::t_noise_ctl           i_ctl,
    input  logic [2:0]                    i_mode,
    input  logic                          i_tone2,
    input  logic [psg_pkg::ShiftWidth-1:0] i_taps,
    input  logic [psg_pkg::LenWidth-1:0]   i_len,
    input  logic [psg_pkg::ShiftWidth-1:0] i_seed,
    output logic                          o_next_bit
);
    import psg_pkg::*;

    logic                  r_white,  n_white;
    logic [NoiseCntW-1:0]  r_period, n_period;
    logic [NoiseCntW-1:0]  r_count,  n_count;
    logic                  r_phase,  n_phase;
    logic                  r_last,   n_last;
    logic [ShiftWidth-1:0] r_shift,  n_shift;
    logic [NoiseCntW-1:0]  count_dec;
    logic [3:0]            top_pos;
    logic                  feedback;
    logic [ShiftWidth-1:0] shifted;
    logic                  do_shift;

    // Feedback enters at bit length-1, with the length clamped to 1..16.
    always_comb begin
        if (i_len == '0) begin
            top_pos = 4'd0;
        end else if (i_len > LenWidth'(ShiftWidth)) begin
            top_pos = 4'(ShiftWidth - 1);
        end else begin
            top_pos = 4'(i_len - 1'b1);
        end
        feedback = r_white ? ^(r_shift & i_taps) : r_shift[0];
        shifted  = (r_shift >> 1) | (ShiftWidth'(feedback) << top_pos);
    end

    always_comb begin
        n_white   = r_white;
        n_period  = r_period;
        n_count   = r_count;
        n_phase   = r_phase;
        n_last    = r_last;
        n_shift   = r_shift;
        do_shift  = 1'b0;
        count_dec = r_count - 1'b1;
        if (i_ctl.mode_wr) begin
            n_white  = i_mode[2];
            n_period = noise_rate(i_mode[1:0]);
            n_count  = noise_rate(i_mode[1:0]);
            n_shift  = i_seed;
        end else if (i_ctl.step) begin
            if (r_period == '0) begin
                do_shift = !r_last && i_tone2;
                n_last   = i_tone2;
            end else if (count_dec == '0) begin
                n_count  = r_period;
                n_phase  = ~r_phase;
                do_shift = ~r_phase;
            end else begin
                n_count = count_dec;
            end
            if (do_shift) begin
                n_shift = shifted;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_white  <= 1'b0;
            r_period <= '0;
            r_count  <= '0;
            r_phase  <= 1'b0;
            r_last   <= 1'b0;
            r_shift  <= SeedReset;
        end else begin
            r_white  <= n_white;
            r_period <= n_period;
            r_count  <= n_count;
            r_phase  <= n_phase;
            r_last   <= n_last;
            r_shift  <= n_shift;
        end
    end

    assign o_next_bit = n_shift[0];

endmodule

[hdl/psg_tone_noise_generator.sv]
// Top level of the three-tone, one-noise sound generator: input register,
// command decode, prescaler, attenuations and result register.
// Depends on psg_pkg, psg_tone and psg_noise.
//
//   Channel   Direction  Handshake                 Payload
//   input     in         i_in_valid / o_in_ready   i_operation, i_data_byte
//   result    out        o_out_valid / i_out_ready o_tone*_bit, o_noise_bit,
//                                                  o_atten0..3, o_busy_count
//   config    in         i_cfg_we (no wait)        i_cfg_index, i_cfg_data
//
// One transaction per cycle when the output is not stalled: each item is held
// in the input register and then writes the latched voice or attenuation, or steps
// the prescaler and voices, in a single pass into the result register.
// Reset is synchronous and active low and returns all control and voice state to its reset values.
// A stall on the result side holds the result register; the input register
// still takes a transaction while it is empty; o_in_ready drops once it is full.
module psg_tone_noise_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_operation,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_tone0_bit,
    output logic        o_tone1_bit,
    output logic        o_tone2_bit,
    output logic        o_noise_bit,
    output logic [3:0]  o_atten0,
    output logic [3:0]  o_atten1,
    output logic [3:0]  o_atten2,
    output logic [3:0]  o_atten3,
    output logic [5:0]  o_busy_count,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import psg_pkg::*;

    // Configuration registers.
    logic [PreWidth-1:0]   r_tick_div;
    logic [ShiftWidth-1:0] r_taps;
    logic [LenWidth-1:0]   r_len;
    logic [ShiftWidth-1:0] r_seed;

    // Input register.
    logic       r_s1_vld;
    t_op        r_s1_op;
    logic [7:0] r_s1_data;

    // Control state.
    logic [1:0]            r_latch_voice, n_latch_voice;
    logic                  r_latch_atten, n_latch_atten;
    logic [AttenWidth-1:0] r_atten [NumTones+1];
    logic [AttenWidth-1:0] n_atten [NumTones+1];
    logic [ReadyWidth-1:0] r_ready, n_ready;
    logic [PreWidth-1:0]   r_pre, n_pre;
    logic [PreWidth-1:0]   pre_dec;

    // Result register.
    logic                  r_out_vld;
    logic [NumTones-1:0]   r_out_tone;
    logic                  r_out_noise;
    logic [AttenWidth-1:0] r_out_atten [NumTones+1];
    logic [ReadyWidth-1:0] r_out_busy;

    t_tone_ctl           tone_ctl [NumTones];
    t_noise_ctl          noise_ctl;
    logic [NumTones-1:0] tone_next;
    logic                noise_next;
    logic                adv;

    assign adv        = r_s1_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_s1_vld || adv;

    always_comb begin
        n_latch_voice = r_latch_voice;
        n_latch_atten = r_latch_atten;
        n_atten       = r_atten;
        n_ready       = r_ready;
        n_pre         = r_pre;
        pre_dec       = r_pre - 1'b1;
        noise_ctl     = '0;
        for (int i = 0; i < NumTones; i++) begin
            tone_ctl[i] = '0;
        end
        if (adv) begin
            unique case (r_s1_op)
                OpWrite: begin
                    if (r_s1_data[CmdLatchBit]) begin
                        n_latch_voice = r_s1_data[6:5];
                        n_latch_atten = r_s1_data[4];
                    end
                    if (n_latch_atten) begin
                        n_atten[n_latch_voice] = r_s1_data[3:0];
                    end else if (n_latch_voice == NoiseVoice) begin
                        noise_ctl.mode_wr = 1'b1;
                    end else begin
                        for (int i = 0; i < NumTones; i++) begin
                            if (n_latch_voice == 2'(i)) begin
                                tone_ctl[i].wr_lo = r_s1_data[CmdLatchBit];
                                tone_ctl[i].wr_hi = !r_s1_data[CmdLatchBit];
                            end
                        end
                    end
                    n_ready = ReadyLoad;
                end
                OpTick: begin
                    if (r_ready != '0) begin
                        n_ready = r_ready - 1'b1;
                    end
                    n_pre = pre_dec;
                    if (pre_dec == '0) begin
                        n_pre          = r_tick_div;
                        noise_ctl.step = 1'b1;
                        for (int i = 0; i < NumTones; i++) begin
                            tone_ctl[i].step = 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    for (genvar g = 0; g < NumTones; g++) begin : g_tone
        psg_tone u_tone (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (tone_ctl[g]),
            .i_data     (r_s1_data),
            .o_next_bit (tone_next[g])
        );
    end

    // The noise voice sees tone 2 after this step's update.
    psg_noise u_noise (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (noise_ctl),
        .i_mode     (r_s1_data[2:0]),
        .i_tone2    (tone_next[NumTones-1]),
        .i_taps     (r_taps),
        .i_len      (r_len),
        .i_seed     (r_seed),
        .o_next_bit (noise_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_div    <= TickDivReset;
            r_taps        <= TapsReset;
            r_len         <= LenReset;
            r_seed        <= SeedReset;
            r_s1_vld      <= 1'b0;
            r_out_vld     <= 1'b0;
            r_latch_voice <= '0;
            r_latch_atten <= 1'b0;
            r_ready       <= '0;
            r_pre         <= TickDivReset;
            for (int i = 0; i <= NumTones; i++) begin
                r_atten[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CfgTickDivider: r_tick_div <= i_cfg_data;
                    CfgNoiseTaps:   r_taps     <= i_cfg_data;
                    CfgShiftLength: r_len      <= i_cfg_data[LenWidth-1:0];
                    CfgShiftSeed:   r_seed     <= i_cfg_data;
                endcase
            end
            if (o_in_ready) begin
                r_s1_vld <= i_in_valid;
            end
            if (adv) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            r_latch_voice <= n_latch_voice;
            r_latch_atten <= n_latch_atten;
            r_ready       <= n_ready;
            r_pre         <= n_pre;
            r_atten       <= n_atten;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1_op   <= t_op'(i_operation);
            r_s1_data <= i_data_byte;
        end
        if (adv) begin
            r_out_tone  <= tone_next;
            r_out_noise <= noise_next;
            r_out_atten <= n_atten;
            r_out_busy  <= n_ready;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_tone0_bit  = r_out_tone[0];
    assign o_tone1_bit  = r_out_tone[1];
    assign o_tone2_bit  = r_out_tone[2];
    assign o_noise_bit  = r_out_noise;
    assign o_atten0     = r_out_atten[0];
    assign o_atten1     = r_out_atten[1];
    assign o_atten2     = r_out_atten[2];
    assign o_atten3     = r_out_atten[3];
    assign o_busy_count = r_out_busy;

endmodule

[hdl/psg_checker.sv]
// Port-level checks for the sound generator, attached to the top level by bind.
// Depends on psg_tone_noise_generator's port list.
module psg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_tone0_bit,
    input logic        o_tone1_bit,
    input logic        o_tone2_bit,
    input logic        o_noise_bit,
    input logic [3:0]  o_atten0,
    input logic [3:0]  o_atten1,
    input logic [3:0]  o_atten2,
    input logic [3:0]  o_atten3,
    input logic [5:0]  o_busy_count
);

    logic [5:0] r_prev_busy;
    logic       out_txn;

    assign out_txn = o_out_valid && i_out_ready;

    // Busy count of the previous result transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_busy <= '0;
        end else if (out_txn) begin
            r_prev_busy <= o_busy_count;
        end
    end

    a_held_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_busy_count)
            && $stable(o_atten0) && $stable(o_atten1) && $stable(o_atten2)
            && $stable(o_atten3) && $stable(o_tone0_bit) && $stable(o_tone1_bit)
            && $stable(o_tone2_bit) && $stable(o_noise_bit))
        else $error("result changed while stalled");

    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid straight after reset");

    a_busy_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_busy_count <= 6'd32)
        else $error("busy count above its load value");

    // Each result either reloads the counter, moves it down by one, or holds it at zero.
    a_busy_sequence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_txn |-> (o_busy_count == 6'd32)
            || (r_prev_busy != 6'd0 && o_busy_count == r_prev_busy - 6'd1)
            || (r_prev_busy == 6'd0 && o_busy_count == 6'd0))
        else $error("busy count out of sequence");

endmodule

bind psg_tone_noise_generator psg_checker u_psg_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_tone0_bit  (o_tone0_bit),
    .o_tone1_bit  (o_tone1_bit),
    .o_tone2_bit  (o_tone2_bit),
    .o_noise_bit  (o_noise_bit),
    .o_atten0     (o_atten0),
    .o_atten1     (o_atten1),
    .o_atten2     (o_atten2),
    .o_atten3     (o_atten3),
    .o_busy_count (o_busy_count)
);
